FILE: hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, character codes and the content-length key table for the
// STOMP frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

   // width of the body length counter
   localparam int LENGTH_BITS = 32;

   // result queue sizing
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_BSL   = 8'h5c;

   // length of the "content-length" key
   localparam logic [3:0] LEN_KEY_LEN = 4'd14;

   typedef enum logic [2:0] {
      PH_START,
      PH_CMD,
      PH_KEY,
      PH_VALUE,
      PH_BODY_COUNT,
      PH_BODY_NUL,
      PH_BODY_TEXT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CMD,
      KIND_KEY,
      KIND_VALUE,
      KIND_BODY
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_CMD_BYTE,
      ERR_NO_COLON,
      ERR_BAD_ESCAPE,
      ERR_ESC_LINE_END,
      ERR_NO_NUL,
      ERR_BAD_LENGTH
   } err_type;

   // parser state
   typedef struct packed {
      phase_type              phase;
      logic                   pending_cr;
      logic                   escape_pending;
      logic                   line_nonempty;
      logic [3:0]             key_match_pos;
      logic                   key_matches;
      logic                   len_active;
      logic                   len_digits;
      logic                   has_length;
      logic [LENGTH_BITS-1:0] body_remaining;
   } pst_type;

   // one result item
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      kind_type   kind;
      logic       field_end;
      logic       frame_end;
      err_type    err;
   } res_type;

   // one partial parse step: new state and at most one result
   typedef struct packed {
      pst_type st;
      logic    emit;
      logic    fail;
      res_type res;
   } mstep_type;

   // whole item: new state and up to two results
   typedef struct packed {
      pst_type    st;
      logic [1:0] n;
      res_type    r0;
      res_type    r1;
   } step_type;

   // characters of the content-length key
   function automatic logic [7:0] len_key_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = "c";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "l";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/stomp_frame_parser_core.sv
// ----------------------------------------------------------------------------
// stomp_frame_parser_core
// Byte-wide STOMP frame parser: classifies command, header and body bytes,
// decodes header escapes and tracks content-length.
// ----------------------------------------------------------------------------
// Queue: a result is written to the 4-entry output queue at the edge that
//   accepts its byte and is offered on rsp_ once it reaches the queue head.
// Throughput: one byte per cycle while req_stall is low; a byte that yields two
//   results takes two queue entries, and req_stall rises while the queue has
//   fewer than two free entries.
// Reset: synchronous, clears the parser to start of frame and empties the queue.
`default_nettype none

module stomp_frame_parser_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_has_byte,
   output logic [1:0]      rsp_field_kind,
   output logic            rsp_field_end,
   output logic            rsp_frame_end,
   output logic [2:0]      rsp_error_code
);
   import sfp_pkg::*;

   // ------------------------------------------------------------------------
   // parse helpers
   // ------------------------------------------------------------------------

   function automatic pst_type idle_state();
      pst_type s;
      s.phase          = PH_START;
      s.pending_cr     = 1'b0;
      s.escape_pending = 1'b0;
      s.line_nonempty  = 1'b0;
      s.key_match_pos  = 4'd0;
      s.key_matches    = 1'b1;
      s.len_active     = 1'b0;
      s.len_digits     = 1'b0;
      s.has_length     = 1'b0;
      s.body_remaining = '0;
      return s;
   endfunction

   function automatic pst_type new_line(input pst_type s);
      pst_type t;
      t                = s;
      t.line_nonempty  = 1'b0;
      t.escape_pending = 1'b0;
      t.key_match_pos  = 4'd0;
      t.key_matches    = 1'b1;
      t.len_active     = 1'b0;
      t.len_digits     = 1'b0;
      return t;
   endfunction

   function automatic res_type make_res(input logic [7:0] d, input logic h,
                                        input kind_type k, input logic fe,
                                        input logic fr, input err_type e);
      res_type r;
      r.data      = d;
      r.has_byte  = h;
      r.kind      = k;
      r.field_end = fe;
      r.frame_end = fr;
      r.err       = e;
      return r;
   endfunction

   function automatic kind_type kind_of(input phase_type p);
      kind_type k;
      case (p)
         PH_KEY:                                 k = KIND_KEY;
         PH_VALUE:                               k = KIND_VALUE;
         PH_BODY_COUNT, PH_BODY_NUL, PH_BODY_TEXT: k = KIND_BODY;
         default:                                k = KIND_CMD;
      endcase
      return k;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_cmd_char(input logic [7:0] b);
      return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")) ||
             is_digit(b) || (b == "_");
   endfunction

   // bit 8 set marks an escape byte that has no meaning
   function automatic logic [8:0] decode_escape(input logic [7:0] b);
      logic [8:0] d;
      case (b)
         "r":     d = {1'b0, CH_CR};
         "n":     d = {1'b0, CH_LF};
         "c":     d = {1'b0, CH_COLON};
         CH_BSL:  d = {1'b0, CH_BSL};
         default: d = 9'h100;
      endcase
      return d;
   endfunction

   function automatic mstep_type no_res(input pst_type s);
      mstep_type m;
      m.st   = s;
      m.emit = 1'b0;
      m.fail = 1'b0;
      m.res  = make_res(8'h00, 1'b0, KIND_CMD, 1'b0, 1'b0, ERR_NONE);
      return m;
   endfunction

   // error marker, parser back to start of frame
   function automatic mstep_type fail_step(input pst_type s, input err_type code);
      mstep_type m;
      m.st   = idle_state();
      m.emit = 1'b1;
      m.fail = 1'b1;
      m.res  = make_res(8'h00, 1'b0, kind_of(s.phase), 1'b0, 1'b0, code);
      return m;
   endfunction

   // decoded key byte, advancing the content-length match
   function automatic mstep_type key_byte(input pst_type s, input logic [7:0] d);
      mstep_type m;
      m = no_res(s);
      if (s.key_matches && (s.key_match_pos < LEN_KEY_LEN) &&
          (d == len_key_char(s.key_match_pos))) begin
         m.st.key_match_pos = s.key_match_pos + 4'd1;
      end else begin
         m.st.key_matches = 1'b0;
      end
      m.emit = 1'b1;
      m.res  = make_res(d, 1'b1, KIND_KEY, 1'b0, 1'b0, ERR_NONE);
      return m;
   endfunction

   // decoded value byte, accumulating the length digits with saturation
   function automatic mstep_type value_byte(input pst_type s, input logic [7:0] d);
      mstep_type              m;
      logic [LENGTH_BITS+3:0] prod;
      m = no_res(s);
      if (s.len_active) begin
         if (is_digit(d)) begin
            prod = {1'b0, s.body_remaining, 3'b000} +
                   {3'b000, s.body_remaining, 1'b0} +
                   {{LENGTH_BITS{1'b0}}, d[3:0]};
            if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
               m.st.body_remaining = '1;
            end else begin
               m.st.body_remaining = prod[LENGTH_BITS-1:0];
            end
            m.st.len_digits = 1'b1;
         end else if (s.len_digits) begin
            m.st.len_active = 1'b0;
            m.st.has_length = 1'b1;
         end else begin
            return fail_step(s, ERR_BAD_LENGTH);
         end
      end
      m.emit = 1'b1;
      m.res  = make_res(d, 1'b1, KIND_VALUE, 1'b0, 1'b0, ERR_NONE);
      return m;
   endfunction

   // one byte of a line other than LF
   function automatic mstep_type line_byte(input pst_type s, input logic [7:0] b);
      mstep_type  m;
      pst_type    t;
      logic [8:0] dec;
      t   = s;
      dec = decode_escape(b);
      case (s.phase)
         PH_START, PH_CMD: begin
            if (!is_cmd_char(b)) begin
               m = fail_step(s, ERR_CMD_BYTE);
            end else begin
               m          = no_res(s);
               m.emit     = 1'b1;
               m.res      = make_res(b, 1'b1, KIND_CMD, 1'b0, 1'b0, ERR_NONE);
               m.st.phase = PH_CMD;
            end
         end
         PH_KEY: begin
            t.line_nonempty = 1'b1;
            if (t.escape_pending) begin
               if (b == CH_COLON) begin
                  m = fail_step(t, ERR_ESC_LINE_END);
               end else if (dec[8]) begin
                  m = fail_step(t, ERR_BAD_ESCAPE);
               end else begin
                  t.escape_pending = 1'b0;
                  m = key_byte(t, dec[7:0]);
               end
            end else if (b == CH_BSL) begin
               m                   = no_res(t);
               m.st.escape_pending = 1'b1;
            end else if (b == CH_COLON) begin
               m      = no_res(t);
               m.emit = 1'b1;
               m.res  = make_res(8'h00, 1'b0, KIND_KEY, 1'b1, 1'b0, ERR_NONE);
               if (t.key_matches && (t.key_match_pos == LEN_KEY_LEN)) begin
                  m.st.len_active     = 1'b1;
                  m.st.len_digits     = 1'b0;
                  m.st.body_remaining = '0;
               end
               m.st.phase = PH_VALUE;
            end else begin
               m = key_byte(t, b);
            end
         end
         default: begin
            if (t.escape_pending) begin
               if (dec[8]) begin
                  m = fail_step(t, ERR_BAD_ESCAPE);
               end else begin
                  t.escape_pending = 1'b0;
                  m = value_byte(t, dec[7:0]);
               end
            end else if (b == CH_BSL) begin
               m                   = no_res(t);
               m.st.escape_pending = 1'b1;
            end else begin
               m = value_byte(t, b);
            end
         end
      endcase
      return m;
   endfunction

   // end of a line
   function automatic mstep_type line_end(input pst_type s);
      mstep_type m;
      pst_type   t;
      t = s;
      case (s.phase)
         PH_CMD: begin
            m          = no_res(new_line(s));
            m.emit     = 1'b1;
            m.res      = make_res(8'h00, 1'b0, KIND_CMD, 1'b1, 1'b0, ERR_NONE);
            m.st.phase = PH_KEY;
         end
         PH_KEY: begin
            if (s.line_nonempty) begin
               m = fail_step(s, ERR_NO_COLON);
            end else begin
               m = no_res(new_line(s));
               if (!s.has_length) begin
                  m.st.phase = PH_BODY_TEXT;
               end else if (s.body_remaining != '0) begin
                  m.st.phase = PH_BODY_COUNT;
               end else begin
                  m.st.phase = PH_BODY_NUL;
               end
            end
         end
         PH_VALUE: begin
            if (s.escape_pending) begin
               m = fail_step(s, ERR_ESC_LINE_END);
            end else if (s.len_active && !s.len_digits) begin
               m = fail_step(s, ERR_BAD_LENGTH);
            end else begin
               if (s.len_active) begin
                  t.has_length = 1'b1;
               end
               m          = no_res(new_line(t));
               m.emit     = 1'b1;
               m.res      = make_res(8'h00, 1'b0, KIND_VALUE, 1'b1, 1'b0, ERR_NONE);
               m.st.phase = PH_KEY;
            end
         end
         default: begin
            m = no_res(s);
         end
      endcase
      return m;
   endfunction

   // complete handling of one input byte
   function automatic step_type parse_item(input pst_type s, input logic [7:0] b);
      step_type  o;
      pst_type   cur;
      mstep_type m1;
      mstep_type m2;
      logic      go;
      o.st = s;
      o.n  = 2'd0;
      o.r0 = make_res(8'h00, 1'b0, KIND_CMD, 1'b0, 1'b0, ERR_NONE);
      o.r1 = o.r0;
      m1   = no_res(s);
      m2   = no_res(s);
      cur  = s;
      go   = 1'b1;
      case (s.phase)
         PH_BODY_COUNT: begin
            o.n                 = 2'd1;
            o.r0                = make_res(b, 1'b1, KIND_BODY, 1'b0, 1'b0, ERR_NONE);
            o.st.body_remaining = s.body_remaining - LENGTH_BITS'(1);
            if (o.st.body_remaining == '0) begin
               o.st.phase = PH_BODY_NUL;
            end
         end
         PH_BODY_NUL, PH_BODY_TEXT: begin
            o.n = 2'd1;
            if (b == CH_NUL) begin
               o.r0 = make_res(8'h00, 1'b0, KIND_BODY, 1'b1, 1'b1, ERR_NONE);
               o.st = idle_state();
            end else if (s.phase == PH_BODY_NUL) begin
               m1   = fail_step(s, ERR_NO_NUL);
               o.r0 = m1.res;
               o.st = m1.st;
            end else begin
               o.r0 = make_res(b, 1'b1, KIND_BODY, 1'b0, 1'b0, ERR_NONE);
            end
         end
         PH_START, PH_CMD, PH_KEY, PH_VALUE: begin
            // held CR: dropped before LF, else a line byte of its own
            if (cur.pending_cr) begin
               cur.pending_cr = 1'b0;
               if (b == CH_LF) begin
                  m1  = line_end(cur);
                  cur = m1.st;
                  go  = 1'b0;
               end else begin
                  m1  = line_byte(cur, CH_CR);
                  cur = m1.st;
                  go  = !m1.fail;
               end
            end
            if (go) begin
               if (b == CH_CR) begin
                  cur.pending_cr = 1'b1;
               end else if (b == CH_LF) begin
                  m2  = line_end(cur);
                  cur = m2.st;
               end else begin
                  m2  = line_byte(cur, b);
                  cur = m2.st;
               end
            end
            o.st = cur;
            if (m1.emit) begin
               o.r0 = m1.res;
               o.n  = 2'd1;
               if (m2.emit) begin
                  o.r1 = m2.res;
                  o.n  = 2'd2;
               end
            end else if (m2.emit) begin
               o.r0 = m2.res;
               o.n  = 2'd1;
            end
         end
         default: begin
            o.st = idle_state();
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // signals
   // ------------------------------------------------------------------------

   pst_type                  pst_ff;
   pst_type                  pst_in;
   step_type                 step_out;
   res_type                  fifo_ff [FIFO_DEPTH];
   res_type                  head;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] fifo_count_ff;
   logic [FIFO_CNT_BITS-1:0] fifo_count_in;
   logic                     req_fire;
   logic                     rsp_fire;
   logic [1:0]               push_n;

   // ------------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------------

   // need room for two results before taking a byte
   assign req_stall = fifo_count_ff > FIFO_CNT_BITS'(FIFO_DEPTH - 2);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = fifo_count_ff != '0;
   assign rsp_fire  = rsp_valid && !rsp_stall;

   // ------------------------------------------------------------------------
   // parse and state update
   // ------------------------------------------------------------------------

   always_comb begin
      step_out = parse_item(pst_ff, req_in_byte);
      pst_in   = req_fire ? step_out.st : pst_ff;
      push_n   = req_fire ? step_out.n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= idle_state();
      end else begin
         pst_ff <= pst_in;
      end
   end

   // ------------------------------------------------------------------------
   // result queue
   // ------------------------------------------------------------------------

   always_comb begin
      wr_ptr_in     = wr_ptr_ff + FIFO_PTR_BITS'(push_n);
      rd_ptr_in     = rd_ptr_ff + FIFO_PTR_BITS'(rsp_fire);
      fifo_count_in = fifo_count_ff + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= step_out.r0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_BITS'(1)] <= step_out.r1;
      end
   end

   // output fields from the queue head
   assign head           = fifo_ff[rd_ptr_ff];
   assign rsp_data_byte  = head.data;
   assign rsp_has_byte   = head.has_byte;
   assign rsp_field_kind = head.kind;
   assign rsp_field_end  = head.field_end;
   assign rsp_frame_end  = head.frame_end;
   assign rsp_error_code = head.err;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a held CR only exists outside the body
   a_cr_not_in_body: assert property (@(posedge clock) disable iff (reset)
      pst_ff.pending_cr |-> !(pst_ff.phase == PH_BODY_COUNT ||
                              pst_ff.phase == PH_BODY_NUL ||
                              pst_ff.phase == PH_BODY_TEXT))
      else $error("held CR in body phase");

   // counted body always has bytes left
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (pst_ff.phase == PH_BODY_COUNT) |-> (pst_ff.body_remaining != '0))
      else $error("counted body with zero length");

   // an error result carries no byte and ends nothing
   a_err_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_NONE)) |->
         (!rsp_has_byte && !rsp_field_end && !rsp_frame_end))
      else $error("error result with byte or end flag");

endmodule

`default_nettype wire

FILE: tb/sv/stomp_frame_parser_checker.sv
// ----------------------------------------------------------------------------
// stomp_frame_parser_checker
// Watches both channels of the STOMP frame parser and predicts every result
// item from the accepted bytes. Each accepted result item is compared field
// by field with the oldest prediction. Mismatches and surplus items are
// counted, and the number of predictions still open is reported.
// ----------------------------------------------------------------------------
`default_nettype none

module stomp_frame_parser_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [7:0] rsp_data_byte,
   input  wire logic       rsp_has_byte,
   input  wire logic [1:0] rsp_field_kind,
   input  wire logic       rsp_field_end,
   input  wire logic       rsp_frame_end,
   input  wire logic [2:0] rsp_error_code,
   output int              mismatch_count,
   output int              open_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import sfp_pkg::*;

   localparam logic [8*14-1:0]        LEN_KEY = "content-length";
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   // parser state as the frame goes by
   phase_type              phase;
   logic                   pend_cr;
   logic                   esc_open;
   logic                   line_used;
   logic [3:0]             key_pos;
   logic                   key_ok;
   logic                   len_active;
   logic                   len_digits;
   logic                   len_known;
   logic [LENGTH_BITS-1:0] body_left;

   res_type expected_q[$];
   int      errs = 0;

   assign mismatch_count = errs;

   function automatic void post_result(logic [7:0] d, logic has, kind_type k,
                                       logic fe, logic fre, err_type e);
      res_type r;
      r.data      = d;
      r.has_byte  = has;
      r.kind      = k;
      r.field_end = fe;
      r.frame_end = fre;
      r.err       = e;
      expected_q.push_back(r);
   endfunction

   function automatic void restart_line();
      line_used  = 1'b0;
      esc_open   = 1'b0;
      key_pos    = '0;
      key_ok     = 1'b1;
      len_active = 1'b0;
      len_digits = 1'b0;
   endfunction

   function automatic void restart_all();
      phase     = PH_START;
      pend_cr   = 1'b0;
      restart_line();
      len_known = 1'b0;
      body_left = '0;
   endfunction

   function automatic kind_type phase_kind();
      if (phase == PH_KEY) return KIND_KEY;
      if (phase == PH_VALUE) return KIND_VALUE;
      if (phase >= PH_BODY_COUNT) return KIND_BODY;
      return KIND_CMD;
   endfunction

   // an error drops the byte and throws the parser back to frame start
   function automatic void raise_error(err_type e);
      post_result(8'h00, 1'b0, phase_kind(), 1'b0, 1'b0, e);
      restart_all();
   endfunction

   function automatic bit is_word_char(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             (b >= "0" && b <= "9") || b == "_";
   endfunction

   // bit 8 set means the escape letter is not legal
   function automatic logic [8:0] unescape(logic [7:0] b);
      if (b == "r") return {1'b0, CH_CR};
      if (b == "n") return {1'b0, CH_LF};
      if (b == "c") return {1'b0, CH_COLON};
      if (b == CH_BSL) return {1'b0, CH_BSL};
      return 9'h100;
   endfunction

   // key byte, also tracks the match against content-length
   function automatic void key_char(logic [7:0] d);
      int idx;
      idx = 13 - int'(key_pos);
      if (key_ok && key_pos < LEN_KEY_LEN && d == LEN_KEY[8*idx +: 8])
         key_pos = key_pos + 4'd1;
      else
         key_ok = 1'b0;
      post_result(d, 1'b1, KIND_KEY, 1'b0, 1'b0, ERR_NONE);
   endfunction

   // value byte, accumulates the length digits with saturation
   function automatic bit value_char(logic [7:0] d);
      logic [LENGTH_BITS+4:0] grown;
      if (len_active) begin
         if (d >= "0" && d <= "9") begin
            grown = {5'd0, body_left} * (LENGTH_BITS+5)'(10) +
                    (LENGTH_BITS+5)'(d - 8'h30);
            body_left = (grown > {5'd0, LEN_MAX}) ? LEN_MAX : grown[LENGTH_BITS-1:0];
            len_digits = 1'b1;
         end else if (len_digits) begin
            len_active = 1'b0;
            len_known  = 1'b1;
         end else begin
            raise_error(ERR_BAD_LENGTH);
            return 1'b0;
         end
      end
      post_result(d, 1'b1, KIND_VALUE, 1'b0, 1'b0, ERR_NONE);
      return 1'b1;
   endfunction

   // one line byte other than LF, returns 0 on error
   function automatic bit line_char(logic [7:0] b);
      logic [8:0] d;
      case (phase)
         PH_START, PH_CMD: begin
            if (!is_word_char(b)) begin
               raise_error(ERR_CMD_BYTE);
               return 1'b0;
            end
            post_result(b, 1'b1, KIND_CMD, 1'b0, 1'b0, ERR_NONE);
            phase = PH_CMD;
            return 1'b1;
         end
         PH_KEY: begin
            line_used = 1'b1;
            if (esc_open) begin
               if (b == CH_COLON) begin
                  raise_error(ERR_ESC_LINE_END);
                  return 1'b0;
               end
               d = unescape(b);
               if (d[8]) begin
                  raise_error(ERR_BAD_ESCAPE);
                  return 1'b0;
               end
               esc_open = 1'b0;
               key_char(d[7:0]);
            end else if (b == CH_BSL) begin
               esc_open = 1'b1;
            end else if (b == CH_COLON) begin
               post_result(8'h00, 1'b0, KIND_KEY, 1'b1, 1'b0, ERR_NONE);
               if (key_ok && key_pos == LEN_KEY_LEN) begin
                  len_active = 1'b1;
                  len_digits = 1'b0;
                  body_left  = '0;
               end
               phase = PH_VALUE;
            end else begin
               key_char(b);
            end
            return 1'b1;
         end
         default: begin
            if (esc_open) begin
               d = unescape(b);
               if (d[8]) begin
                  raise_error(ERR_BAD_ESCAPE);
                  return 1'b0;
               end
               esc_open = 1'b0;
               return value_char(d[7:0]);
            end
            if (b == CH_BSL) begin
               esc_open = 1'b1;
               return 1'b1;
            end
            return value_char(b);
         end
      endcase
      return 1'b1;
   endfunction

   // end of a line (LF, or CR LF)
   function automatic void line_done();
      case (phase)
         PH_START: ;
         PH_CMD: begin
            post_result(8'h00, 1'b0, KIND_CMD, 1'b1, 1'b0, ERR_NONE);
            phase = PH_KEY;
            restart_line();
         end
         PH_KEY: begin
            if (line_used) begin
               raise_error(ERR_NO_COLON);
            end else begin
               restart_line();
               if (!len_known) phase = PH_BODY_TEXT;
               else if (body_left != '0) phase = PH_BODY_COUNT;
               else phase = PH_BODY_NUL;
            end
         end
         default: begin
            if (esc_open) begin
               raise_error(ERR_ESC_LINE_END);
            end else if (len_active && !len_digits) begin
               raise_error(ERR_BAD_LENGTH);
            end else begin
               if (len_active) len_known = 1'b1;
               post_result(8'h00, 1'b0, KIND_VALUE, 1'b1, 1'b0, ERR_NONE);
               phase = PH_KEY;
               restart_line();
            end
         end
      endcase
   endfunction

   // predict the result items of one accepted byte
   function automatic void parse_byte(logic [7:0] b);
      if (phase == PH_BODY_COUNT) begin
         post_result(b, 1'b1, KIND_BODY, 1'b0, 1'b0, ERR_NONE);
         body_left = body_left - LENGTH_BITS'(1);
         if (body_left == '0) phase = PH_BODY_NUL;
         return;
      end
      if (phase == PH_BODY_NUL || phase == PH_BODY_TEXT) begin
         if (b == CH_NUL) begin
            post_result(8'h00, 1'b0, KIND_BODY, 1'b1, 1'b1, ERR_NONE);
            restart_all();
         end else if (phase == PH_BODY_NUL) begin
            raise_error(ERR_NO_NUL);
         end else begin
            post_result(b, 1'b1, KIND_BODY, 1'b0, 1'b0, ERR_NONE);
         end
         return;
      end
      // a held CR is dropped before LF, else it counts as a line byte
      if (pend_cr) begin
         pend_cr = 1'b0;
         if (b == CH_LF) begin
            line_done();
            return;
         end
         if (!line_char(CH_CR)) return;
      end
      if (b == CH_CR) pend_cr = 1'b1;
      else if (b == CH_LF) line_done();
      else void'(line_char(b));
   endfunction

   // compare one result item with the oldest prediction
   function automatic void check_result();
      res_type want;
      if (expected_q.size() == 0) begin
         errs++;
         if (errs <= 10)
            $display("%0t: rsp item with no prediction open: data=%02h err=%0d",
                     $realtime, rsp_data_byte, rsp_error_code);
         return;
      end
      want = expected_q.pop_front();
      if (want.data !== rsp_data_byte || want.has_byte !== rsp_has_byte ||
          want.kind !== rsp_field_kind || want.field_end !== rsp_field_end ||
          want.frame_end !== rsp_frame_end || want.err !== rsp_error_code) begin
         errs++;
         if (errs <= 10) begin
            $display("%0t: rsp mismatch: want data=%02h has=%0d kind=%0d fend=%0d",
                     $realtime, want.data, want.has_byte, want.kind, want.field_end);
            $display("   want frend=%0d err=%0d / got data=%02h has=%0d kind=%0d",
                     want.frame_end, want.err, rsp_data_byte, rsp_has_byte,
                     rsp_field_kind);
            $display("   got fend=%0d frend=%0d err=%0d",
                     rsp_field_end, rsp_frame_end, rsp_error_code);
         end
      end
   endfunction

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         restart_all();
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall) parse_byte(req_in_byte);
         if (rsp_valid && !rsp_stall) check_result();
      end
      open_count = expected_q.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the STOMP frame parser testbench. Sends a short directed byte
// sequence, then random frames, mostly well formed with random content and
// some with injected faults, garbled bytes or noise. Both sides idle and
// stall at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sfp_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 1000000;

   // fault kinds injected into random frames
   typedef enum int {
      FLT_NONE,
      FLT_CMD,
      FLT_NO_COLON,
      FLT_BAD_ESC,
      FLT_ESC_EOL,
      FLT_ESC_COLON,
      FLT_BAD_LEN,
      FLT_NO_NUL,
      FLT_GARBLE
   } fault_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_stall   = 1'b0;

   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_byte;
   logic [1:0] rsp_field_kind;
   logic       rsp_field_end;
   logic       rsp_frame_end;
   logic [2:0] rsp_error_code;

   int mismatch_count;
   int open_count;

   logic [7:0] frame_bytes[$];
   int         items_sent   = 0;
   int         cycle_count  = 0;
   bit         calm         = 1'b0;
   int         stall_run    = 0;
   bit         stall_level  = 1'b0;

   stomp_frame_parser_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_field_kind (rsp_field_kind),
      .rsp_field_end  (rsp_field_end),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_error_code (rsp_error_code)
   );

   stomp_frame_parser_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_field_kind (rsp_field_kind),
      .rsp_field_end  (rsp_field_end),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_error_code (rsp_error_code),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver stalls in runs: mostly short, a few long, none while calm
   always @(negedge clock) begin
      int r;
      if (stall_run == 0) begin
         r = $urandom_range(0, 99);
         if (calm) begin
            stall_level = 1'b0;
            stall_run   = 1;
         end else if (r < 65) begin
            stall_level = 1'b0;
            stall_run   = $urandom_range(1, 8);
         end else if (r < 95) begin
            stall_level = 1'b1;
            stall_run   = $urandom_range(1, 3);
         end else begin
            stall_level = 1'b1;
            stall_run   = $urandom_range(10, 40);
         end
      end
      stall_run = stall_run - 1;
      rsp_stall <= stall_level;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 50);
   endfunction

   // offer one byte and hold it until accepted; called at a falling edge
   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) push_byte(frame_bytes[i]);
      frame_bytes.delete();
   endtask

   // stop sending until every predicted item has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (open_count != 0);
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endfunction

   function automatic void add_eol();
      if ($urandom_range(0, 3) == 0) frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
   endfunction

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0:       return 8'("A" + $urandom_range(0, 25));
         1:       return 8'("a" + $urandom_range(0, 25));
         2:       return 8'("0" + $urandom_range(0, 9));
         default: return 8'("_");
      endcase
   endfunction

   function automatic logic [7:0] bad_word_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             (b >= "0" && b <= "9") || b == "_" || b == CH_LF || b == CH_CR);
      return b;
   endfunction

   // plain header text, no line end and no backslash
   function automatic logic [7:0] text_byte(bit colon_ok);
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 19) == 0) b = 8'($urandom_range(0, 255));
         else b = 8'($urandom_range(8'h20, 8'h7e));
      end while (b == CH_LF || b == CH_CR || b == CH_BSL ||
                 (!colon_ok && b == CH_COLON));
      return b;
   endfunction

   function automatic void add_escape();
      frame_bytes.push_back(CH_BSL);
      case ($urandom_range(0, 3))
         0:       frame_bytes.push_back("r");
         1:       frame_bytes.push_back("n");
         2:       frame_bytes.push_back("c");
         default: frame_bytes.push_back(CH_BSL);
      endcase
   endfunction

   function automatic void add_key(int n);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) add_escape();
         else frame_bytes.push_back(text_byte(1'b0));
      end
   endfunction

   function automatic void add_value(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            add_escape();
         end else if (r < 15) begin
            // lone CR inside the value
            frame_bytes.push_back(CH_CR);
            frame_bytes.push_back(text_byte(1'b1));
         end else begin
            frame_bytes.push_back(text_byte(1'b1));
         end
      end
   endfunction

   // content-length header; returns the length it sets
   function automatic int add_length_header();
      int v;
      add_str("content-length:");
      v = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      if ($urandom_range(0, 4) == 0) add_str("0");
      add_str($sformatf("%0d", v));
      if ($urandom_range(0, 9) == 0) add_str(";x");
      add_eol();
      return v;
   endfunction

   // header line that breaks in the way the fault asks
   function automatic void add_bad_header(fault_type f);
      logic [7:0] b;
      case (f)
         FLT_NO_COLON: add_key($urandom_range(1, 4));
         FLT_BAD_ESC: begin
            add_key($urandom_range(0, 3));
            add_str(":");
            add_value($urandom_range(0, 3));
            do b = 8'($urandom_range(8'h21, 8'h7e));
            while (b == "r" || b == "n" || b == "c" || b == CH_BSL || b == CH_COLON);
            frame_bytes.push_back(CH_BSL);
            frame_bytes.push_back(b);
         end
         FLT_ESC_EOL: begin
            add_key($urandom_range(0, 3));
            add_str(":");
            add_value($urandom_range(0, 3));
            frame_bytes.push_back(CH_BSL);
         end
         FLT_ESC_COLON: begin
            add_key($urandom_range(0, 3));
            frame_bytes.push_back(CH_BSL);
            frame_bytes.push_back(CH_COLON);
         end
         default: begin
            add_str("content-length:");
            case ($urandom_range(0, 4))
               0:       add_str("+5");
               1:       add_str("-1");
               2:       add_str(" 7");
               3:       add_str("\\n4");
               default: ;
            endcase
         end
      endcase
      add_eol();
   endfunction

   // one random frame, well formed unless a fault is drawn
   function automatic void build_frame();
      fault_type fault;
      int        nh;
      int        body_len;
      bit        counted;
      bit        sat_used;
      int        pos;
      fault    = ($urandom_range(0, 99) < 22) ? fault_type'($urandom_range(1, 8)) : FLT_NONE;
      counted  = 1'b0;
      sat_used = 1'b0;
      body_len = 0;
      // noise between frames
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) if ($urandom_range(0, 2) == 0) add_eol();
      // command line
      repeat ($urandom_range(1, 7)) frame_bytes.push_back(word_char());
      if (fault == FLT_CMD) frame_bytes.push_back(bad_word_char());
      add_eol();
      // header lines
      nh = $urandom_range(0, 4);
      for (int h = 0; h < nh; h++) begin
         if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 19) == 0) begin
               // saturating length, overridden by the next header
               add_str("content-length:99999999999");
               add_eol();
               sat_used = 1'b1;
            end
            body_len = add_length_header();
            counted  = 1'b1;
         end else begin
            add_key($urandom_range(0, 6));
            add_str(":");
            add_value($urandom_range(0, 8));
            add_eol();
         end
      end
      if (fault >= FLT_NO_COLON && fault <= FLT_BAD_LEN) add_bad_header(fault);
      add_eol();
      // body
      if (counted) begin
         repeat (body_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         if (fault == FLT_NO_NUL) frame_bytes.push_back(8'($urandom_range(1, 255)));
         else frame_bytes.push_back(CH_NUL);
      end else begin
         repeat (($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10))
            frame_bytes.push_back(8'($urandom_range(1, 255)));
         frame_bytes.push_back(CH_NUL);
      end
      // overwrite one byte anywhere in the frame
      if (fault == FLT_GARBLE && !sat_used) begin
         pos = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[pos] = 8'($urandom_range(0, 255));
      end
   endfunction

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: skipped empty lines, command byte range, CR LF, empty body,
      // extreme byte, held CR before a non-LF, escape before the colon in a
      // key, and a key line with an open escape but no colon
      add_str("\r\n\nA_z9\r\n\n");
      frame_bytes.push_back(CH_NUL);
      frame_bytes.push_back(8'hff);
      frame_bytes.push_back(CH_CR);
      add_str("x");
      add_str("A\nk\\:");
      add_str("A\nk\\\n");
      send_frame();

      // random frames
      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= ITEM_TARGET / 2) begin
            wait_idle();
            paused = 1'b1;
         end
         calm = (items_sent >= 200 && items_sent < 400);
         build_frame();
         send_frame();
      end
      calm = 1'b0;

      // drain, then let the block settle
      wait_idle();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
